/* sv/srms_pkg.sv */
// Package for the sliding-window RMS unit: field widths, fixed constants
// and the sequencer state type. No dependencies.
package srms_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int FREQ_W     = 16;
   localparam int SQ_W       = 31;
   localparam int RMS_W      = 16;
   localparam int DECI_SCALE = 10;

   localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd500;
   localparam logic [RMS_W-1:0]  RMS_MAX    = 16'h8000;

   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_NDIV,
      STATE_NSET,
      STATE_RING_RD,
      STATE_RING_UPD,
      STATE_QDIV,
      STATE_SQRT,
      STATE_PUSH
   } srms_state_type;

endpackage

/* sv/sliding_window_rms_unit.sv */
// A new beat is accepted only in idle: req_ready stays low from an accepted
// beat until its result is loaded into the output register, so beats are
// not overlapped. The window divide, mean divide and root steps all run
// through the single shared compare-subtract unit, one after another.
// Reset: synchronous, active high; clears pointers, sum and handshake state,
// frequency returns to 50.0 Hz. Ring contents are not cleared.
module sliding_window_rms_unit #(
   parameter int SAMPLE_RATE_HZ = 8000,
   parameter int WINDOW_DEPTH   = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [srms_pkg::FREQ_W-1:0]       csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [srms_pkg::SAMPLE_W-1:0] req_sample_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [srms_pkg::RMS_W-1:0]        rsp_rms_value,
   output logic                              rsp_window_clamped
);

   localparam int K      = SAMPLE_RATE_HZ * srms_pkg::DECI_SCALE;
   localparam int K_W    = $clog2(K + 1);
   localparam int AW     = $clog2(WINDOW_DEPTH);
   localparam int N_W    = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = srms_pkg::SQ_W + AW;
   localparam int ROOT_W = (SUM_W + 1) / 2;
   localparam int WORK_W = (K_W > 2 * ROOT_W) ? K_W : 2 * ROOT_W;
   localparam int QUO_W  = (K_W > SUM_W) ? K_W : SUM_W;
   localparam int ALU_W  = ROOT_W + 3;
   localparam int CNT_W  = $clog2(QUO_W + 1);

   srms_pkg::srms_state_type state_ff, state_in;

   logic [srms_pkg::FREQ_W-1:0]       freq_ff;
   logic [srms_pkg::SAMPLE_W-1:0]     sample_ff, sample_in;
   logic [srms_pkg::SQ_W-1:0]         sq_ff, sq_in;
   logic [WORK_W-1:0]                 work_ff, work_in;
   logic [QUO_W-1:0]                  quo_ff, quo_in;
   logic [ALU_W-1:0]                  rem_ff, rem_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [N_W-1:0]                    n_ff, n_in;
   logic                              clamp_ff, clamp_in;
   logic [AW-1:0]                     wp_ff, wp_in;
   logic [AW-1:0]                     wr_ptr_ff, wr_ptr_in;
   logic [N_W-1:0]                    rd_ptr_ff, rd_ptr_in;
   logic [SUM_W-1:0]                  sum_ff, sum_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [srms_pkg::RMS_W-1:0]        rms_ff, rms_in;
   logic                              out_clamp_ff, out_clamp_in;

   logic [ALU_W-1:0]                  alu_a, alu_b, alu_diff;
   logic                              alu_ge;
   logic                              ring_wr_en, ring_rd_en;
   logic [AW-1:0]                     ring_rd_addr;
   logic [srms_pkg::SQ_W-1:0]         ring_rd_data;
   logic [srms_pkg::SAMPLE_W-1:0]     mag;
   logic [srms_pkg::SQ_W-1:0]         mag_sq;
   logic [K_W-1:0]                    n_quo;
   logic [ROOT_W-1:0]                 root;
   logic                              last_step;

   srms_step_unit #(.W(ALU_W)) u_step (
      .a    (alu_a),
      .b    (alu_b),
      .diff (alu_diff),
      .ge   (alu_ge)
   );

   srms_ring #(.DEPTH(WINDOW_DEPTH), .AW(AW), .DW(srms_pkg::SQ_W)) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (wp_ff),
      .wr_data (sq_ff),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   assign mag    = sample_ff[srms_pkg::SAMPLE_W-1] ? (~sample_ff + 1'b1) : sample_ff;
   assign mag_sq = srms_pkg::SQ_W'(mag) * srms_pkg::SQ_W'(mag);
   assign n_quo  = quo_ff[K_W-1:0];
   assign root   = quo_ff[ROOT_W-1:0];

   always_comb begin
      case (state_ff)
         srms_pkg::STATE_NDIV:  last_step = (cnt_ff == CNT_W'(K_W - 1));
         srms_pkg::STATE_QDIV:  last_step = (cnt_ff == CNT_W'(SUM_W - 1));
         srms_pkg::STATE_SQRT:  last_step = (cnt_ff == CNT_W'(ROOT_W - 1));
         default:               last_step = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srms_pkg::STATE_IDLE: begin
            if (req_valid) state_in = srms_pkg::STATE_NDIV;
         end
         srms_pkg::STATE_NDIV: begin
            if (last_step) state_in = srms_pkg::STATE_NSET;
         end
         srms_pkg::STATE_NSET:     state_in = srms_pkg::STATE_RING_RD;
         srms_pkg::STATE_RING_RD:  state_in = srms_pkg::STATE_RING_UPD;
         srms_pkg::STATE_RING_UPD: state_in = srms_pkg::STATE_QDIV;
         srms_pkg::STATE_QDIV: begin
            if (last_step) state_in = srms_pkg::STATE_SQRT;
         end
         srms_pkg::STATE_SQRT: begin
            if (last_step) state_in = srms_pkg::STATE_PUSH;
         end
         srms_pkg::STATE_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = srms_pkg::STATE_IDLE;
         end
         default: state_in = srms_pkg::STATE_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready    = (state_ff == srms_pkg::STATE_IDLE);
      sample_in    = sample_ff;
      sq_in        = sq_ff;
      work_in      = work_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff + 1'b1;
      n_in         = n_ff;
      clamp_in     = clamp_ff;
      wp_in        = wp_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      sum_in       = sum_ff;
      rms_in       = rms_ff;
      out_clamp_in = out_clamp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ring_wr_en   = 1'b0;
      ring_rd_en   = 1'b0;
      ring_rd_addr = (AW'(0));
      alu_a        = {rem_ff[ALU_W-2:0], work_ff[WORK_W-1]};
      alu_b        = ALU_W'(freq_ff);

      case (state_ff)
         srms_pkg::STATE_IDLE: begin
            sample_in = req_sample_value;
            work_in   = WORK_W'(K) << (WORK_W - K_W);
            quo_in    = '0;
            rem_in    = '0;
            cnt_in    = '0;
         end
         srms_pkg::STATE_NDIV: begin
            sq_in   = mag_sq;
            rem_in  = alu_ge ? alu_diff : alu_a;
            quo_in  = {quo_ff[QUO_W-2:0], alu_ge};
            work_in = work_ff << 1;
         end
         srms_pkg::STATE_NSET: begin
            if (n_quo > K_W'(WINDOW_DEPTH)) begin
               n_in     = N_W'(WINDOW_DEPTH);
               clamp_in = 1'b1;
            end else if (n_quo == '0) begin
               n_in     = N_W'(1);
               clamp_in = 1'b0;
            end else begin
               n_in     = n_quo[N_W-1:0];
               clamp_in = 1'b0;
            end
         end
         srms_pkg::STATE_RING_RD: begin
            wp_in        = (N_W'(wr_ptr_ff) >= n_ff) ? AW'(0) : wr_ptr_ff;
            ring_rd_en   = 1'b1;
            ring_rd_addr = wp_in;
         end
         srms_pkg::STATE_RING_UPD: begin
            ring_wr_en = 1'b1;
            if (N_W'(wp_ff) < rd_ptr_ff) begin
               sum_in = sum_ff - SUM_W'(ring_rd_data) + SUM_W'(sq_ff);
            end else begin
               rd_ptr_in = N_W'(wp_ff) + 1'b1;
               sum_in    = sum_ff + SUM_W'(sq_ff);
            end
            wr_ptr_in = ((N_W'(wp_ff) + 1'b1) >= n_ff) ? AW'(0) : wp_ff + 1'b1;
            work_in   = WORK_W'(sum_in) << (WORK_W - SUM_W);
            quo_in    = '0;
            rem_in    = '0;
            cnt_in    = '0;
         end
         srms_pkg::STATE_QDIV: begin
            alu_b   = ALU_W'(n_ff);
            rem_in  = alu_ge ? alu_diff : alu_a;
            quo_in  = {quo_ff[QUO_W-2:0], alu_ge};
            work_in = work_ff << 1;
            if (last_step) begin
               work_in = WORK_W'(quo_in[SUM_W-1:0]) << (WORK_W - 2 * ROOT_W);
               quo_in  = '0;
               rem_in  = '0;
               cnt_in  = '0;
            end
         end
         srms_pkg::STATE_SQRT: begin
            alu_a   = {rem_ff[ALU_W-3:0], work_ff[WORK_W-1 -: 2]};
            alu_b   = ALU_W'({root, 2'b01});
            rem_in  = alu_ge ? alu_diff : alu_a;
            quo_in  = {quo_ff[QUO_W-2:0], alu_ge};
            work_in = work_ff << 2;
         end
         srms_pkg::STATE_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_clamp_in = clamp_ff;
               rms_in = (root > ROOT_W'(srms_pkg::RMS_MAX)) ? srms_pkg::RMS_MAX
                                                            : root[srms_pkg::RMS_W-1:0];
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srms_pkg::STATE_IDLE;
         freq_ff      <= srms_pkg::FREQ_RESET;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            freq_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      sq_ff        <= sq_in;
      work_ff      <= work_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      n_ff         <= n_in;
      clamp_ff     <= clamp_in;
      wp_ff        <= wp_in;
      rms_ff       <= rms_in;
      out_clamp_ff <= out_clamp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rms_value      = rms_ff;
   assign rsp_window_clamped = out_clamp_ff;

`ifndef SYNTHESIS
   a_rd_ptr_range: assert property (@(posedge clock) disable iff (reset)
      rd_ptr_ff <= N_W'(WINDOW_DEPTH))
      else $error("read pointer beyond ring depth");

   a_wr_ptr_range: assert property (@(posedge clock) disable iff (reset)
      N_W'(wr_ptr_ff) < N_W'(WINDOW_DEPTH))
      else $error("write pointer beyond ring depth");

   a_window_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srms_pkg::STATE_RING_RD || state_ff == srms_pkg::STATE_RING_UPD ||
       state_ff == srms_pkg::STATE_QDIV) |-> (n_ff != '0 && n_ff <= N_W'(WINDOW_DEPTH)))
      else $error("window length out of range during update");

   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_ready) && state_ff == srms_pkg::STATE_PUSH |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_wp_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == srms_pkg::STATE_RING_UPD |-> N_W'(wp_ff) < n_ff)
      else $error("ring slot outside window");
`endif

endmodule

/* sv/srms_step_unit.sv */
// Shared compare-subtract unit used for every divide and square-root step.
// Depends on nothing.
module srms_step_unit #(
   parameter int W = 23
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic [W-1:0] diff,
   output logic         ge
);

   logic borrow;

   always_comb begin
      {borrow, diff} = {1'b0, a} - {1'b0, b};
      ge = ~borrow;
   end

endmodule

/* sv/srms_ring.sv */
// Ring of squared samples: one write port and one registered read port.
// Contents are undefined until written. No dependencies.
module srms_ring #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int DW    = 31
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
